// ===== rtl/mcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsa_pkg
// Shared constants, types and helpers for the min-cost subsequence-avoid block.
// ----------------------------------------------------------------------------
`default_nettype none

package mcsa_pkg;

   localparam int PATTERN_LEN = 4;
   localparam int ACC_W       = 48;
   localparam int OUT_W       = 48;
   localparam int SYM_W       = 8;
   localparam int COST_W      = 30;
   localparam int PAT_W       = 32;
   localparam int PAT_CHARS   = PAT_W / SYM_W;
   localparam int CMP_W       = (ACC_W > OUT_W) ? ACC_W : OUT_W;

   localparam logic [PAT_W-1:0] PAT_RESET = 32'h6861_7264;
   localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};
   localparam logic [OUT_W-1:0] OUT_MAX   = {OUT_W{1'b1}};

   typedef logic [ACC_W-1:0] acc_type;
   typedef logic [PATTERN_LEN-1:0][ACC_W-1:0] acc_row_type;

   typedef struct packed {
      logic              valid;
      logic              last;
      logic [SYM_W-1:0]  sym;
      logic [COST_W-1:0] cost;
   } step_type;

   function automatic logic [SYM_W-1:0] pattern_char(input logic [PAT_W-1:0] word,
                                                     input int j);
      logic [SYM_W-1:0] ch;
      ch = '0;
      if (j >= 0 && j < PAT_CHARS) begin
         ch = word[(PAT_CHARS-1-j)*SYM_W +: SYM_W];
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mcsa_cell.sv =====
// ----------------------------------------------------------------------------
// mcsa_cell
// One prefix-length cell: holds the running cost for its prefix and takes the
// cost handed over by its left neighbor when the symbol matches there and that cost is lower.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsa_cell (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mcsa_pkg::step_type         step,
   input  wire logic                       is_head,
   input  wire logic [mcsa_pkg::SYM_W-1:0] pat_char,
   input  wire mcsa_pkg::acc_type          left_cost,
   input  wire logic                       left_match,
   output mcsa_pkg::acc_type               cost_ff,
   output mcsa_pkg::acc_type               next_cost,
   output logic                            match,
   output logic                            sat_hit
);

   logic [mcsa_pkg::ACC_W:0] sum;
   logic                     add_sat;
   logic                     unreach;
   mcsa_pkg::acc_type        added;
   mcsa_pkg::acc_type        kept;
   mcsa_pkg::acc_type        reset_cost;
   mcsa_pkg::acc_type        cost_in;

   assign match      = (step.sym == pat_char);
   assign sum        = {1'b0, cost_ff} + (mcsa_pkg::ACC_W+1)'(step.cost);
   assign add_sat    = sum >= {1'b0, mcsa_pkg::ACC_MAX};
   assign unreach    = (cost_ff == mcsa_pkg::ACC_MAX);
   assign added      = (unreach || add_sat) ? mcsa_pkg::ACC_MAX : sum[mcsa_pkg::ACC_W-1:0];
   assign kept       = match ? added : cost_ff;
   assign next_cost  = (left_match && (left_cost < kept)) ? left_cost : kept;
   assign sat_hit    = match && !unreach && add_sat;
   assign reset_cost = is_head ? '0 : mcsa_pkg::ACC_MAX;

   always_comb begin
      cost_in = cost_ff;
      if (step.valid) begin
         cost_in = step.last ? reset_cost : next_cost;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff <= reset_cost;
      end else begin
         cost_ff <= cost_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/mcsa_reduce.sv =====
// ----------------------------------------------------------------------------
// mcsa_reduce
// Snapshot of the final prefix costs, minimum over them, clamp to the output
// width and result register toward the response channel.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsa_reduce (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire mcsa_pkg::acc_row_type      snap,
   input  wire logic                       snap_sat,
   output logic                            can_load,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [mcsa_pkg::OUT_W-1:0]      rsp_tdata,
   output logic                            rsp_tuser
);

   logic                    hold_valid_ff, hold_valid_in;
   mcsa_pkg::acc_row_type   hold_ff;
   logic                    hold_sat_ff;
   logic                    out_valid_ff, out_valid_in;
   logic [mcsa_pkg::OUT_W-1:0] out_data_ff;
   logic                    out_sat_ff;
   logic                    advance;
   mcsa_pkg::acc_type       best;
   logic [mcsa_pkg::CMP_W-1:0] best_ext;
   logic                    over;

   assign advance  = hold_valid_ff && (!out_valid_ff || rsp_tready);
   assign can_load = !hold_valid_ff || advance;

   always_comb begin
      best = hold_ff[0];
      for (int j = 1; j < mcsa_pkg::PATTERN_LEN; j++) begin
         if (hold_ff[j] < best) begin
            best = hold_ff[j];
         end
      end
   end

   assign best_ext = mcsa_pkg::CMP_W'(best);
   assign over     = best_ext > mcsa_pkg::CMP_W'(mcsa_pkg::OUT_MAX);

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (load) begin
         hold_valid_in = 1'b1;
      end else if (advance) begin
         hold_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hold_ff     <= snap;
         hold_sat_ff <= snap_sat;
      end
      if (advance) begin
         out_data_ff <= over ? mcsa_pkg::OUT_MAX : mcsa_pkg::OUT_W'(best_ext);
         out_sat_ff  <= hold_sat_ff || over;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_sat_ff;

endmodule

`default_nettype wire

// ===== rtl/min_cost_subsequence_avoid.sv =====
// ----------------------------------------------------------------------------
// min_cost_subsequence_avoid
// Least total deletion cost so that the configured pattern never survives as
// a subsequence, one prefix-length cell per pattern character.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle, no gaps between strings, unless both the
// snapshot and result registers hold results; each result passes both.
// The cell row updates all prefix costs in the cycle a request is accepted.
// Reset (synchronous): cells clear to zero cost at prefix 0, unreachable
// elsewhere; pipeline empties; pattern register returns to "hard".
`default_nettype none

module min_cost_subsequence_avoid (
   input  wire logic        clock,
   input  wire logic        reset,
   // csr_data: pattern_word[31:0]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [31:0] csr_data,
   // req_tdata: symbol[7:0], delete_cost[37:8], zero [39:38]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tlast,
   // rsp_tdata: min_total_cost[47:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,
   // rsp_tuser: saturated[0]
   output logic             rsp_tuser
);

   localparam int N = mcsa_pkg::PATTERN_LEN;

   logic [mcsa_pkg::PAT_W-1:0] pattern_ff;
   logic                       sat_ff, sat_in;
   logic                       can_load;
   mcsa_pkg::step_type         step;
   mcsa_pkg::acc_row_type      cost_row;
   mcsa_pkg::acc_row_type      next_row;
   logic [N-1:0]               match;
   logic [N-1:0]               sat_hit;
   logic                       any_hit;
   logic                       load;

   assign csr_ready  = 1'b1;
   assign req_tready = can_load;

   assign step.valid = req_tvalid && req_tready;
   assign step.last  = req_tlast;
   assign step.sym   = req_tdata[mcsa_pkg::SYM_W-1:0];
   assign step.cost  = req_tdata[mcsa_pkg::SYM_W +: mcsa_pkg::COST_W];

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         mcsa_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .step       (step),
            .is_head    ((g == 0) ? 1'b1 : 1'b0),
            .pat_char   (mcsa_pkg::pattern_char(pattern_ff, g)),
            .left_cost  ((g == 0) ? mcsa_pkg::ACC_MAX : cost_row[(g == 0) ? 0 : g-1]),
            .left_match ((g == 0) ? 1'b0 : match[(g == 0) ? 0 : g-1]),
            .cost_ff    (cost_row[g]),
            .next_cost  (next_row[g]),
            .match      (match[g]),
            .sat_hit    (sat_hit[g])
         );
      end
   endgenerate

   assign any_hit = |sat_hit;
   assign load    = step.valid && step.last;

   always_comb begin
      sat_in = sat_ff;
      if (step.valid) begin
         sat_in = step.last ? 1'b0 : (sat_ff || any_hit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= mcsa_pkg::PAT_RESET;
         sat_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            pattern_ff <= csr_data;
         end
         sat_ff <= sat_in;
      end
   end

   mcsa_reduce u_reduce (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .snap       (next_row),
      .snap_sat   (sat_ff || any_hit),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

// ===== rtl/mcsa_checker.sv =====
// ----------------------------------------------------------------------------
// mcsa_checker
// Port-level checks on the min-cost subsequence-avoid block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mcsa_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [47:0] rsp_tdata,
   input wire logic        rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && req_tlast, 2))
      else $error("response without a last request two cycles before");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with empty output");

   a_max_means_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata != 48'hFFFF_FFFF_FFFF)
      else $error("maximum cost reported without saturation");

endmodule

bind min_cost_subsequence_avoid mcsa_checker u_mcsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for min_cost_subsequence_avoid: drives symbol strings
// with deletion costs under several pattern settings, predicts the least
// deletion cost and saturation flag per string and compares every response against them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam logic [mcsa_pkg::COST_W-1:0] COST_MAX = {mcsa_pkg::COST_W{1'b1}};
   localparam int CYCLE_LIMIT  = 50_000;
   localparam int DRAIN_CYCLES = 8;
   localparam int RANDOM_ITEMS = 260;

   typedef struct {
      logic [mcsa_pkg::OUT_W-1:0] total;
      logic                       saturated;
   } total_type;

   class avoid_cost_scoreboard;
      logic [mcsa_pkg::PAT_W-1:0] pattern;
      mcsa_pkg::acc_type          prefix_cost [mcsa_pkg::PATTERN_LEN];
      bit                         sat_seen;
      total_type                  expected_totals [$];
      int                         mismatches;

      function new();
         pattern    = mcsa_pkg::PAT_RESET;
         mismatches = 0;
         clear_costs();
      endfunction

      function void clear_costs();
         prefix_cost[0] = '0;
         for (int j = 1; j < mcsa_pkg::PATTERN_LEN; j++) prefix_cost[j] = mcsa_pkg::ACC_MAX;
         sat_seen = 1'b0;
      endfunction

      function logic [mcsa_pkg::SYM_W-1:0] char_at(int j);
         logic [mcsa_pkg::PAT_W-1:0] shifted;
         if (j < 0 || j >= mcsa_pkg::PAT_CHARS) return '0;
         shifted = pattern >> (mcsa_pkg::SYM_W * (mcsa_pkg::PAT_CHARS - 1 - j));
         return shifted[mcsa_pkg::SYM_W-1:0];
      endfunction

      function mcsa_pkg::acc_type add_sat(mcsa_pkg::acc_type a,
                                          logic [mcsa_pkg::COST_W-1:0] b);
         if (a == mcsa_pkg::ACC_MAX) return mcsa_pkg::ACC_MAX;
         if (mcsa_pkg::acc_type'(b) >= mcsa_pkg::ACC_MAX - a) begin
            sat_seen = 1'b1;
            return mcsa_pkg::ACC_MAX;
         end
         return a + mcsa_pkg::acc_type'(b);
      endfunction

      function void note_symbol(logic [mcsa_pkg::SYM_W-1:0] sym,
                                logic [mcsa_pkg::COST_W-1:0] cost, logic last);
         mcsa_pkg::acc_type prev [mcsa_pkg::PATTERN_LEN];
         mcsa_pkg::acc_type v;
         mcsa_pkg::acc_type best;
         total_type         t;
         prev = prefix_cost;
         for (int j = 0; j < mcsa_pkg::PATTERN_LEN; j++) begin
            v = prev[j];
            if (sym == char_at(j)) v = add_sat(v, cost);
            if (j > 0 && sym == char_at(j - 1) && prev[j-1] < v) v = prev[j-1];
            prefix_cost[j] = v;
         end
         if (!last) return;
         best = prefix_cost[0];
         for (int j = 1; j < mcsa_pkg::PATTERN_LEN; j++)
            if (prefix_cost[j] < best) best = prefix_cost[j];
         t.total     = best;
         t.saturated = sat_seen;
         expected_totals = {expected_totals, t};
         clear_costs();
      endfunction

      function void check_total(logic [mcsa_pkg::OUT_W-1:0] total, logic saturated);
         total_type t;
         if (expected_totals.size() == 0) begin
            mismatches++;
            if (mismatches < 100)
               $display("%0t: unexpected response total=%h saturated=%b",
                        $time, total, saturated);
            return;
         end
         t = expected_totals.pop_front();
         if (total !== t.total) begin
            mismatches++;
            if (mismatches < 100)
               $display("%0t: min_total_cost expected %h actual %h", $time, t.total, total);
         end
         if (saturated !== t.saturated) begin
            mismatches++;
            if (mismatches < 100)
               $display("%0t: saturated expected %b actual %b", $time, t.saturated, saturated);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [31:0] csr_data   = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   avoid_cost_scoreboard board;
   int gap_pct = 6;
   int cycles  = 0;

   min_cost_subsequence_avoid DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= !reset && (gap_pct == 0 || $urandom_range(99) >= gap_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) board.check_total(rsp_tdata, rsp_tuser);
   end

   task automatic send_request(logic [mcsa_pkg::SYM_W-1:0] sym,
                               logic [mcsa_pkg::COST_W-1:0] cost, logic last);
      while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, cost, sym};
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      board.note_symbol(sym, cost, last);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (board.expected_totals.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_pattern(logic [mcsa_pkg::PAT_W-1:0] word);
      wait_drained();
      csr_valid <= 1'b1;
      csr_data  <= word;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.pattern = word;
   endtask

   task automatic send_word(logic [31:0] chars, logic [mcsa_pkg::COST_W-1:0] cost);
      for (int i = 0; i < 4; i++)
         send_request(chars[31 - 8*i -: 8], cost + mcsa_pkg::COST_W'(i), i == 3);
   endtask

   task automatic run_random(int count);
      int                          sent;
      int                          len;
      int                          pos;
      bit                          ordered;
      logic [mcsa_pkg::SYM_W-1:0]  sym;
      logic [mcsa_pkg::COST_W-1:0] cost;
      sent = 0;
      while (sent < count) begin
         len     = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(1, 10);
         ordered = ($urandom_range(1) == 1);
         pos     = 0;
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
               sym = mcsa_pkg::SYM_W'($urandom_range(255));
            end else if (ordered) begin
               sym = board.char_at(pos % mcsa_pkg::PATTERN_LEN);
               if ($urandom_range(1)) pos++;
            end else begin
               sym = board.char_at($urandom_range(mcsa_pkg::PATTERN_LEN - 1));
            end
            case ($urandom_range(9))
               0:       cost = '0;
               1:       cost = COST_MAX;
               2, 3, 4: cost = mcsa_pkg::COST_W'($urandom_range(15));
               default: cost = mcsa_pkg::COST_W'($urandom());
            endcase
            send_request(sym, cost, i == len - 1);
         end
         sent += len;
      end
   endtask

   initial begin
      board = new();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      send_request("h", COST_MAX, 1'b1);
      send_request("a", COST_MAX, 1'b1);
      send_request(8'h00, '0, 1'b1);
      send_request(8'hFF, COST_MAX, 1'b1);
      send_word("hard", 30'd5);
      for (int i = 0; i < 8; i++)
         send_request(8'("hhaarrdd" >> (8 * (7 - i))), mcsa_pkg::COST_W'(i + 1), i == 7);
      send_word("drah", 30'd9);
      send_word("hard", COST_MAX - 3);
      run_random(RANDOM_ITEMS);

      write_pattern(32'h0000_0000);
      run_random(RANDOM_ITEMS);
      write_pattern(32'hFFFF_FFFF);
      run_random(RANDOM_ITEMS);
      write_pattern("aaaa");
      run_random(RANDOM_ITEMS);
      write_pattern($urandom());
      run_random(RANDOM_ITEMS);
      write_pattern(32'h00FF_00FF);
      run_random(RANDOM_ITEMS);
      write_pattern(mcsa_pkg::PAT_RESET);

      // hold both sides busy with no idle cycles
      gap_pct = 0;
      run_random(RANDOM_ITEMS);
      gap_pct = 6;

      wait_drained();
      if (board.mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/mcsa_pkg.sv
rtl/mcsa_cell.sv
rtl/mcsa_reduce.sv
rtl/min_cost_subsequence_avoid.sv
rtl/mcsa_checker.sv
test/tb.sv
